// File: src/fm_two_operator_voice_core_defines.svh
`ifndef FM_TWO_OPERATOR_VOICE_CORE_DEFINES_SVH
`define FM_TWO_OPERATOR_VOICE_CORE_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define FMV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmv check failed");

// Checks that a condition holds in the cycle after its trigger.
`define FMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmv check failed");

`endif

// File: src/fmv_pkg.sv
`default_nettype none

package fmv_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int PHASE_BITS = 32;
    localparam int QUARTER = SINE_ENTRIES / 4;
    localparam int ADDR_BITS = $clog2(SINE_ENTRIES);
    localparam int QUAD_BITS = ADDR_BITS - 2;
    localparam logic [QUAD_BITS:0] QUARTER_W = (QUAD_BITS + 1)'(QUARTER);
    localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - PHASE_BITS);

    localparam logic signed [35:0] DEV_MAX = 36'sh7_FFFF_FFFF;
    localparam logic signed [35:0] DEV_MIN = 36'sh8_0000_0000;

    localparam logic [14:0] AMPLITUDE_RESET = 15'd8192;
    localparam logic [20:0] NOTE_LENGTH_RESET = 21'd44100;
    localparam logic [20:0] NOTE_LENGTH_MAX = 21'd1048576;

    localparam logic [2:0] REG_CARRIER_STEP = 3'd0;
    localparam logic [2:0] REG_MODULATOR_STEP = 3'd1;
    localparam logic [2:0] REG_INDEX_START = 3'd2;
    localparam logic [2:0] REG_INDEX_STEP = 3'd3;
    localparam logic [2:0] REG_AMPLITUDE = 3'd4;
    localparam logic [2:0] REG_NOTE_LENGTH = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int BACK_STAGES = 6;
    localparam int ITEM_CAPACITY = QUEUE_DEPTH + BACK_STAGES;

    typedef struct packed {
        logic [31:0]        carrier_step;
        logic [31:0]        modulator_step;
        logic signed [35:0] index_start;
        logic signed [31:0] index_step;
        logic [20:0]        note_length;
    } fmv_cfg_t;

    typedef struct packed {
        logic [31:0]        carrier_phase;
        logic [31:0]        modulator_phase;
        logic signed [35:0] deviation;
        logic               note_last;
    } fmv_job_t;

    typedef logic [14:0] sine_rom_t [0:QUARTER];

    // Quarter-wave table from an odd Taylor polynomial evaluated in Q30.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint unsigned k;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned s;
        longint unsigned y;
        longint unsigned v;
        for (k = 0; k <= longint'(QUARTER); k++)
        begin
            u = (k << 30) / QUARTER;
            u2 = (u * u) >> 30;
            s = 64'd3864;
            s = 64'd172272 - ((s * u2) >> 30);
            s = 64'd5026995 - ((s * u2) >> 30);
            s = 64'd85569305 - ((s * u2) >> 30);
            s = 64'd693598668 - ((s * u2) >> 30);
            s = 64'd1686629713 - ((s * u2) >> 30);
            y = (s * u) >> 30;
            v = (y * 64'd32767 + (64'd1 << 29)) >> 30;
            rom[k[QUAD_BITS:0]] = (v > 64'd32767) ? 15'h7FFF : v[14:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic logic signed [15:0] sine_lookup(input logic [31:0] phase);
        logic [ADDR_BITS-1:0] idx;
        logic [1:0]           quad;
        logic [QUAD_BITS-1:0] r;
        logic [QUAD_BITS:0]   addr;
        logic [15:0]          mag;
        idx = phase[31 -: ADDR_BITS];
        quad = idx[ADDR_BITS-1 -: 2];
        r = idx[QUAD_BITS-1:0];
        addr = quad[0] ? (QUARTER_W - {1'b0, r}) : {1'b0, r};
        mag = {1'b0, SINE_ROM[addr]};
        return signed'(quad[1] ? (16'd0 - mag) : mag);
    endfunction

endpackage

`default_nettype wire

// File: src/fmv_front.sv
`default_nettype none

module fmv_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fmv_pkg::fmv_cfg_t cfg,
    input  wire logic             in_valid,
    input  wire logic             restart,
    output logic                  in_stall,
    input  wire logic             queue_full,
    output logic                  push,
    output fmv_pkg::fmv_job_t     job
);

    logic [31:0]        carrier_reg;
    logic [31:0]        carrier_next;
    logic [31:0]        modulator_reg;
    logic [31:0]        modulator_next;
    logic signed [35:0] dev_reg;
    logic signed [35:0] dev_next;
    logic [19:0]        count_reg;
    logic [19:0]        count_next;
    logic               pending_reg;
    logic               pending_next;

    logic               start;
    logic [31:0]        cur_carrier;
    logic [31:0]        cur_modulator;
    logic signed [35:0] cur_dev;
    logic [19:0]        cur_count;
    logic [20:0]        len_eff;
    logic               last;
    logic signed [36:0] dev_sum;

    assign in_stall = queue_full;
    assign push = in_valid && !queue_full;

    always_comb
    begin
        start = restart || pending_reg;
        cur_carrier = start ? 32'd0 : carrier_reg;
        cur_modulator = start ? 32'd0 : modulator_reg;
        cur_dev = start ? cfg.index_start : dev_reg;
        cur_count = start ? 20'd0 : count_reg;

        if (cfg.note_length == 21'd0)
        begin
            len_eff = 21'd1;
        end
        else if (cfg.note_length > fmv_pkg::NOTE_LENGTH_MAX)
        begin
            len_eff = fmv_pkg::NOTE_LENGTH_MAX;
        end
        else
        begin
            len_eff = cfg.note_length;
        end
        last = ({1'b0, cur_count} + 21'd1) >= len_eff;

        job.carrier_phase = cur_carrier;
        job.modulator_phase = cur_modulator;
        job.deviation = cur_dev;
        job.note_last = last;

        dev_sum = 37'(cur_dev) + 37'(cfg.index_step);

        carrier_next = carrier_reg;
        modulator_next = modulator_reg;
        dev_next = dev_reg;
        count_next = count_reg;
        pending_next = pending_reg;
        if (push)
        begin
            carrier_next = (cur_carrier + (cfg.carrier_step & fmv_pkg::PHASE_MASK))
                & fmv_pkg::PHASE_MASK;
            modulator_next = (cur_modulator + (cfg.modulator_step & fmv_pkg::PHASE_MASK))
                & fmv_pkg::PHASE_MASK;
            if (dev_sum[36] != dev_sum[35])
            begin
                dev_next = dev_sum[36] ? fmv_pkg::DEV_MIN : fmv_pkg::DEV_MAX;
            end
            else
            begin
                dev_next = dev_sum[35:0];
            end
            count_next = last ? cur_count : cur_count + 20'd1;
            pending_next = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg <= '0;
            modulator_reg <= '0;
            dev_reg <= '0;
            count_reg <= '0;
            pending_reg <= 1'b1;
        end
        else
        begin
            carrier_reg <= carrier_next;
            modulator_reg <= modulator_next;
            dev_reg <= dev_next;
            count_reg <= count_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// File: src/fmv_queue.sv
`default_nettype none

module fmv_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire fmv_pkg::fmv_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output fmv_pkg::fmv_job_t      head
);

    fmv_pkg::fmv_job_t mem_reg [fmv_pkg::QUEUE_DEPTH];

    logic [fmv_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [fmv_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [fmv_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [fmv_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [fmv_pkg::QUEUE_CNT_BITS-1:0] count_reg;
    logic [fmv_pkg::QUEUE_CNT_BITS-1:0] count_next;

    assign full = count_reg == fmv_pkg::QUEUE_CNT_BITS'(fmv_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + fmv_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + fmv_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + fmv_pkg::QUEUE_CNT_BITS'(1);
            2'b01:   count_next = count_reg - fmv_pkg::QUEUE_CNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/fmv_back.sv
`default_nettype none

module fmv_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [14:0]       amplitude,
    input  wire logic              empty,
    input  wire fmv_pkg::fmv_job_t head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [15:0]     sample,
    output logic                   note_last
);

    logic               advance;

    logic               s0_valid_reg;
    logic [31:0]        s0_carrier_reg;
    logic signed [35:0] s0_dev_reg;
    logic               s0_last_reg;
    logic signed [15:0] s0_sm_reg;
    logic signed [15:0] s0_sm_next;

    logic               s1_valid_reg;
    logic [31:0]        s1_carrier_reg;
    logic               s1_last_reg;
    logic signed [51:0] s1_prod_reg;
    logic signed [51:0] s1_prod_next;

    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [31:0]        s2_total_reg;
    logic [31:0]        s2_total_next;
    logic signed [51:0] s1_rounded;

    logic               s3_valid_reg;
    logic               s3_last_reg;
    logic signed [15:0] s3_sc_reg;
    logic signed [15:0] s3_sc_next;

    logic               s4_valid_reg;
    logic               s4_last_reg;
    logic signed [31:0] s4_aprod_reg;
    logic signed [31:0] s4_aprod_next;

    logic               out_valid_reg;
    logic signed [15:0] sample_reg;
    logic signed [15:0] sample_next;
    logic               last_reg;
    logic signed [31:0] s4_rounded;

    assign advance = !out_valid_reg || !out_stall;
    assign pop = advance && !empty;

    assign out_valid = out_valid_reg;
    assign sample = sample_reg;
    assign note_last = last_reg;

    always_comb
    begin
        s0_sm_next = fmv_pkg::sine_lookup(head.modulator_phase);
        s1_prod_next = s0_dev_reg * s0_sm_reg;
        s1_rounded = s1_prod_reg + 52'sd16384;
        s2_total_next = (s1_carrier_reg + s1_rounded[46:15]) & fmv_pkg::PHASE_MASK;
        s3_sc_next = fmv_pkg::sine_lookup(s2_total_reg);
        s4_aprod_next = $signed({1'b0, amplitude}) * s3_sc_reg;
        s4_rounded = s4_aprod_reg + 32'sd16384;
        sample_next = s4_rounded[30:15];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_carrier_reg <= head.carrier_phase;
            s0_dev_reg <= head.deviation;
            s0_last_reg <= head.note_last;
            s0_sm_reg <= s0_sm_next;
            s1_carrier_reg <= s0_carrier_reg;
            s1_last_reg <= s0_last_reg;
            s1_prod_reg <= s1_prod_next;
            s2_last_reg <= s1_last_reg;
            s2_total_reg <= s2_total_next;
            s3_last_reg <= s2_last_reg;
            s3_sc_reg <= s3_sc_next;
            s4_last_reg <= s3_last_reg;
            s4_aprod_reg <= s4_aprod_next;
            last_reg <= s4_last_reg;
            sample_reg <= sample_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= !empty;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

endmodule

`default_nettype wire

// File: src/fm_two_operator_voice_core.sv
// Two-operator FM voice: each accepted item yields one 16-bit sample and a note_last flag.
// Input channel: in_valid with in_stall from the block; the item carries the restart bit.
// Output channel: out_valid from the block with out_stall from the receiver; the item
// carries sample and note_last.
// Configuration: cfg_valid, cfg_index and cfg_data; cfg_ready is always high, and a write
// lands at an edge where cfg_valid is high. The user must make writes only while no item
// is in flight; the block does not enforce this. The front updates the phase accumulators
// and the deviation ramp for each accepted item and places a snapshot in a four-entry
// queue; the back runs the two sine lookups and two multiplies in a six-register
// pipeline, so the sustained rate is one item per cycle while the receiver does not stall.
// When the receiver stalls, the back pipeline holds, the queue fills, and in_stall rises
// once four items wait in the queue.
// Reset clears the phases, the ramp and the queue, empties the pipeline, and restores the
// registers (amplitude 8192, note length 44100, others zero); the first item after reset
// begins a new note.
`default_nettype none

module fm_two_operator_voice_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               restart,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      sample,
    output logic                    note_last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [35:0]        cfg_data
);

    fmv_pkg::fmv_cfg_t cfg_reg;
    fmv_pkg::fmv_cfg_t cfg_next;
    logic [14:0]       amplitude_reg;
    logic [14:0]       amplitude_next;

    logic              queue_full;
    logic              queue_empty;
    logic              push;
    logic              pop;
    fmv_pkg::fmv_job_t push_job;
    fmv_pkg::fmv_job_t head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        amplitude_next = amplitude_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                fmv_pkg::REG_CARRIER_STEP:   cfg_next.carrier_step = cfg_data[31:0];
                fmv_pkg::REG_MODULATOR_STEP: cfg_next.modulator_step = cfg_data[31:0];
                fmv_pkg::REG_INDEX_START:    cfg_next.index_start = cfg_data[35:0];
                fmv_pkg::REG_INDEX_STEP:     cfg_next.index_step = cfg_data[31:0];
                fmv_pkg::REG_AMPLITUDE:      amplitude_next = cfg_data[14:0];
                fmv_pkg::REG_NOTE_LENGTH:    cfg_next.note_length = cfg_data[20:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_step <= '0;
            cfg_reg.modulator_step <= '0;
            cfg_reg.index_start <= '0;
            cfg_reg.index_step <= '0;
            cfg_reg.note_length <= fmv_pkg::NOTE_LENGTH_RESET;
            amplitude_reg <= fmv_pkg::AMPLITUDE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
            amplitude_reg <= amplitude_next;
        end
    end

    fmv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .restart    (restart),
        .in_stall   (in_stall),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    fmv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    fmv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .amplitude (amplitude_reg),
        .empty     (queue_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .note_last (note_last)
    );

endmodule

`default_nettype wire

// File: src/fmv_checker.sv
`default_nettype none
`include "fm_two_operator_voice_core_defines.svh"

module fmv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] sample,
    input wire logic        note_last
);

    localparam int CNT_BITS = $clog2(fmv_pkg::ITEM_CAPACITY + 1);
    localparam logic [CNT_BITS-1:0] CAPACITY = CNT_BITS'(fmv_pkg::ITEM_CAPACITY);

    logic                in_take;
    logic                out_take;
    logic [CNT_BITS-1:0] outstanding_reg;
    logic [CNT_BITS-1:0] outstanding_next;

    assign in_take = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        unique case ({in_take, out_take})
            2'b10:   outstanding_next = outstanding_reg + CNT_BITS'(1);
            2'b01:   outstanding_next = outstanding_reg - CNT_BITS'(1);
            default: outstanding_next = outstanding_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A stalled result stays offered and unchanged.
    `FMV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(sample) && $stable(note_last))
    // No result appears without an accepted item behind it.
    `FMV_ASSERT_IMPLY(a_no_extra, clk, rst_n, out_valid, outstanding_reg != '0)
    // Items in flight never exceed what the queue and pipeline can hold.
    `FMV_ASSERT_IMPLY(a_bounded, clk, rst_n, 1'b1, outstanding_reg <= CAPACITY)
    // With every slot taken, the input side must be stalled.
    `FMV_ASSERT_IMPLY(a_full_stall, clk, rst_n, outstanding_reg == CAPACITY, in_stall)

endmodule

bind fm_two_operator_voice_core fmv_checker u_fmv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .note_last (note_last)
);

`default_nettype wire
